/* src/assert_macros.svh */
// assertion macros shared by the mountain car step core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define MCPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// implication checked at every clock edge out of reset
`define MCPS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* src/mcps_pkg.sv */
// types, constants and elaboration-time gravity table maths for the mountain car step core
package mcps_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int POS_W = 18;
    localparam int VEL_W = 14;
    localparam int ACT_W = 2;
    localparam int COS_TABLE_DEPTH_DEF = 1024;

    localparam longint ONE_FX = longint'(1) << FRACTION_BITS;
    localparam longint PUSH_GAIN = (ONE_FX * 2 + 1000) / 2000;
    localparam longint GRAVITY_GAIN = (ONE_FX * 50 + 10000) / 20000;
    localparam longint POS_MIN = -((ONE_FX * 24 + 10) / 20);
    localparam longint POS_MAX = ONE_FX / 2;
    localparam longint POS_RESET = -(ONE_FX / 2);
    localparam longint VEL_MAX = (ONE_FX * 14 + 100) / 200;
    localparam longint POS_SPAN = POS_MAX - POS_MIN + 1;

    // offset from the left bound needs this many bits
    localparam int SPAN_W = $clog2(POS_SPAN);
    // gravity term per table entry, signed
    localparam int GRAV_W = $clog2(GRAVITY_GAIN + 1) + 1;
    // reciprocal scaling for the table index, exact while offset * span < 2^34
    localparam int IDX_SHIFT = 34;

    localparam logic signed [POS_W-1:0] POS_MIN_Q = POS_W'(POS_MIN);
    localparam logic signed [POS_W-1:0] POS_MAX_Q = POS_W'(POS_MAX);
    localparam logic signed [POS_W-1:0] POS_RESET_Q = POS_W'(POS_RESET);
    localparam logic signed [VEL_W-1:0] VEL_MAX_Q = VEL_W'(VEL_MAX);
    localparam logic signed [VEL_W-1:0] VEL_MIN_Q = VEL_W'(-VEL_MAX);

    localparam longint unsigned Q30_ONE = 64'd1 << 30;
    localparam longint unsigned Q30_PI = 64'd3373259426;
    localparam longint unsigned Q30_HALF_PI = 64'd1686629713;

    typedef enum logic [ACT_W-1:0] {
        ACT_LEFT  = 2'd0,
        ACT_NONE  = 2'd1,
        ACT_RIGHT = 2'd2,
        ACT_BAD   = 2'd3
    } action_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pos;
        logic signed [VEL_W-1:0] vel;
    } car_state_t;

    typedef struct packed {
        action_t                 action;
        logic                    new_episode;
        logic signed [POS_W-1:0] start_pos;
        logic signed [VEL_W-1:0] start_vel;
    } step_in_t;

    typedef struct packed {
        car_state_t car;
        logic       done_res;
        logic       bad_action;
    } step_res_t;

    // gravity term round(GRAVITY_GAIN * cos(3p)) for a position code, q30 taylor series
    function automatic logic signed [GRAV_W-1:0] grav_of_pos(input longint p);
        longint unsigned mag;
        longint unsigned a;
        longint unsigned a2;
        longint unsigned term;
        longint unsigned rmag;
        longint          sum;
        longint          cosq;
        longint          prod;
        logic            neg;
        int              k;
        neg = 1'b0;
        mag = (p < 0) ? longint'(-p) : longint'(p);
        a = (64'd3 * mag) << (30 - FRACTION_BITS);
        if (a > Q30_PI) begin
            a = a - Q30_PI;
            neg = 1'b1;
        end else if (a > Q30_HALF_PI) begin
            a = Q30_PI - a;
            neg = 1'b1;
        end
        a2 = (a * a) >> 30;
        term = Q30_ONE;
        sum = longint'(term);
        for (k = 1; k <= 8; k++) begin
            term = (term * a2) >> 30;
            case (k)
                1: term = term / 2;
                2: term = term / 12;
                3: term = term / 30;
                4: term = term / 56;
                5: term = term / 90;
                6: term = term / 132;
                7: term = term / 182;
                8: term = term / 240;
                default: term = '0;
            endcase
            if (k % 2 == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (neg) begin
            sum = -sum;
        end
        // to FRACTION_BITS, nearest, ties away from zero
        rmag = (sum < 0) ? longint'(-sum) : longint'(sum);
        rmag = (rmag + (64'd1 << (30 - FRACTION_BITS - 1))) >> (30 - FRACTION_BITS);
        cosq = (sum < 0) ? -longint'(rmag) : longint'(rmag);
        prod = GRAVITY_GAIN * cosq;
        rmag = (prod < 0) ? longint'(-prod) : longint'(prod);
        rmag = (rmag + (64'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
        prod = (prod < 0) ? -longint'(rmag) : longint'(rmag);
        return GRAV_W'(prod);
    endfunction

endpackage

/* src/mcps_grav_rom.sv */
// gravity term rom with registered read, one entry per position bucket
module mcps_grav_rom #(
    parameter int COS_TABLE_DEPTH = mcps_pkg::COS_TABLE_DEPTH_DEF
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     load,
    input  logic [$clog2(COS_TABLE_DEPTH)-1:0]       addr,
    output logic signed [mcps_pkg::GRAV_W-1:0]       grav
);
    import mcps_pkg::*;

    localparam int IDX_W = $clog2(COS_TABLE_DEPTH);
    localparam longint RESET_IDX =
        ((POS_RESET - POS_MIN) * longint'(COS_TABLE_DEPTH)) / POS_SPAN;
    localparam longint RESET_P =
        POS_MIN + ((2 * RESET_IDX + 1) * POS_SPAN) / (2 * longint'(COS_TABLE_DEPTH));
    localparam logic signed [GRAV_W-1:0] RESET_GRAV = grav_of_pos(RESET_P);

    logic signed [GRAV_W-1:0] rom [COS_TABLE_DEPTH];
    logic signed [GRAV_W-1:0] grav_reg;

    for (genvar gi = 0; gi < COS_TABLE_DEPTH; gi++) begin : g_entry
        // bucket centre position
        localparam longint ENTRY_P =
            POS_MIN + ((2 * longint'(gi) + 1) * POS_SPAN) / (2 * longint'(COS_TABLE_DEPTH));
        assign rom[gi] = grav_of_pos(ENTRY_P);
    end

    // reset value matches the entry for the reset position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grav_reg <= RESET_GRAV;
        end else if (load) begin
            grav_reg <= rom[addr[IDX_W-1:0]];
        end
    end

    assign grav = grav_reg;

endmodule

/* src/mcps_step.sv */
// one physics step: push, gravity, integrate, clamp, and table index of the new position
module mcps_step #(
    parameter int COS_TABLE_DEPTH = mcps_pkg::COS_TABLE_DEPTH_DEF
) (
    input  mcps_pkg::car_state_t                 cur,
    input  logic signed [mcps_pkg::GRAV_W-1:0]   grav,
    input  mcps_pkg::step_in_t                   item,
    output mcps_pkg::car_state_t                 nxt,
    output mcps_pkg::step_res_t                  res,
    output logic [$clog2(COS_TABLE_DEPTH)-1:0]   nxt_idx
);
    import mcps_pkg::*;

    localparam int IDX_W = $clog2(COS_TABLE_DEPTH);
    localparam int VW = VEL_W + 2;
    localparam int XW = POS_W + 1;
    localparam longint IDX_MUL =
        ((longint'(1) << IDX_SHIFT) * longint'(COS_TABLE_DEPTH) + POS_SPAN - 1) / POS_SPAN;
    localparam int MUL_W = $clog2(IDX_MUL + 1);
    localparam int PROD_W = SPAN_W + MUL_W;
    localparam logic [MUL_W-1:0] IDX_MUL_V = MUL_W'(IDX_MUL);
    localparam logic signed [VW-1:0] PUSH_V = VW'(PUSH_GAIN);
    localparam logic signed [VW-1:0] VEL_MAX_V = VW'(VEL_MAX);
    localparam logic signed [XW-1:0] POS_MIN_X = XW'(POS_MIN);
    localparam logic signed [XW-1:0] POS_MAX_X = XW'(POS_MAX);

    logic signed [VW-1:0]     push;
    logic signed [VW-1:0]     v_sum;
    logic signed [VW-1:0]     v_clamped;
    logic signed [XW-1:0]     x_sum;
    logic signed [POS_W-1:0]  x_step;
    logic signed [VW-1:0]     v_step;
    logic signed [POS_W-1:0]  start_pos;
    logic signed [VEL_W-1:0]  start_vel;
    logic signed [XW-1:0]     offset;
    logic [SPAN_W-1:0]        offset_u;
    logic [PROD_W-1:0]        idx_prod;

    always_comb begin
        case (item.action)
            ACT_LEFT:  push = -PUSH_V;
            ACT_RIGHT: push = PUSH_V;
            default:   push = '0;
        endcase
    end

    always_comb begin
        v_sum = VW'(cur.vel) + push - VW'(grav);
        x_sum = XW'(cur.pos) + XW'(v_sum);
        // hitting either wall stops the car
        if (x_sum < POS_MIN_X) begin
            x_step = POS_MIN_Q;
            v_clamped = '0;
        end else if (x_sum > POS_MAX_X) begin
            x_step = POS_MAX_Q;
            v_clamped = '0;
        end else begin
            x_step = x_sum[POS_W-1:0];
            v_clamped = v_sum;
        end
        if (v_clamped > VEL_MAX_V) begin
            v_step = VEL_MAX_V;
        end else if (v_clamped < -VEL_MAX_V) begin
            v_step = -VEL_MAX_V;
        end else begin
            v_step = v_clamped;
        end
    end

    always_comb begin
        if (item.start_pos < POS_MIN_Q) begin
            start_pos = POS_MIN_Q;
        end else if (item.start_pos > POS_MAX_Q) begin
            start_pos = POS_MAX_Q;
        end else begin
            start_pos = item.start_pos;
        end
        if (item.start_vel < VEL_MIN_Q) begin
            start_vel = VEL_MIN_Q;
        end else if (item.start_vel > VEL_MAX_Q) begin
            start_vel = VEL_MAX_Q;
        end else begin
            start_vel = item.start_vel;
        end
    end

    always_comb begin
        res.bad_action = 1'b0;
        if (item.new_episode) begin
            nxt.pos = start_pos;
            nxt.vel = start_vel;
        end else if (item.action == ACT_BAD) begin
            nxt = cur;
            res.bad_action = 1'b1;
        end else begin
            nxt.pos = x_step;
            nxt.vel = v_step[VEL_W-1:0];
        end
        res.car = nxt;
        res.done_res = (nxt.pos == POS_MAX_Q);
    end

    // index = floor(offset * depth / span) by reciprocal multiply
    always_comb begin
        offset = XW'(nxt.pos) - POS_MIN_X;
        offset_u = offset[SPAN_W-1:0];
        idx_prod = PROD_W'(offset_u) * PROD_W'(IDX_MUL_V);
        nxt_idx = idx_prod[IDX_SHIFT +: IDX_W];
    end

endmodule

/* src/mountain_car_physics_step_core.sv */
// mountain car step core: input beat register, step logic, result register
// path: a beat is held in the input beat register, its result then in the result register
// throughput: one beat per cycle unless m_tready stalls; the gravity rom read for the next
//   step is registered together with the car state, so steps follow back to back
// reset (aresetn low, synchronous): position -0.5, velocity zero, both channels empty
`include "assert_macros.svh"

module mountain_car_physics_step_core #(
    parameter int COS_TABLE_DEPTH = mcps_pkg::COS_TABLE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] action, [19:2] start_position, [33:20] start_velocity, [39:34] zero
    input  logic [39:0] s_tdata,
    // [0] new_episode
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [17:0] position, [31:18] velocity, [32] done_res, [33] bad_action, [39:34] zero
    output logic [39:0] m_tdata
);
    import mcps_pkg::*;

    localparam int IDX_W = $clog2(COS_TABLE_DEPTH);

    logic                      in_valid_reg;
    logic                      in_valid_next;
    step_in_t                  in_item_reg;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    step_res_t                 out_res_reg;
    car_state_t                car_reg;
    car_state_t                car_next;
    step_res_t                 step_res;
    logic signed [GRAV_W-1:0]  grav;
    logic [IDX_W-1:0]          nxt_idx;
    logic                      advance;
    logic                      s_accept;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign in_valid_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    mcps_step #(
        .COS_TABLE_DEPTH(COS_TABLE_DEPTH)
    ) u_step (
        .cur     (car_reg),
        .grav    (grav),
        .item    (in_item_reg),
        .nxt     (car_next),
        .res     (step_res),
        .nxt_idx (nxt_idx)
    );

    // rom output always belongs to the position held in car_reg
    mcps_grav_rom #(
        .COS_TABLE_DEPTH(COS_TABLE_DEPTH)
    ) u_grav_rom (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (advance),
        .addr    (nxt_idx),
        .grav    (grav)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            car_reg.pos   <= POS_RESET_Q;
            car_reg.vel   <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                car_reg <= car_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg.action      <= action_t'(s_tdata[1:0]);
            in_item_reg.new_episode <= s_tuser;
            in_item_reg.start_pos   <= s_tdata[19:2];
            in_item_reg.start_vel   <= s_tdata[33:20];
        end
        if (advance) begin
            out_res_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_res_reg.bad_action, out_res_reg.done_res,
                       out_res_reg.car.vel, out_res_reg.car.pos};

    `MCPS_ASSERT(a_pos_range, (car_reg.pos >= POS_MIN_Q) && (car_reg.pos <= POS_MAX_Q), "car position out of range")
    `MCPS_ASSERT(a_vel_range, (car_reg.vel >= VEL_MIN_Q) && (car_reg.vel <= VEL_MAX_Q), "car velocity out of range")
    `MCPS_ASSERT_IMP(a_out_is_state, out_valid_reg, out_res_reg.car == car_reg, "pending result differs from car state")
    `MCPS_ASSERT_IMP(a_done_match, out_valid_reg, out_res_reg.done_res == (out_res_reg.car.pos == POS_MAX_Q), "done flag wrong")
    `MCPS_ASSERT_IMP(a_bad_hold, advance && step_res.bad_action, ##1 $stable(car_reg), "invalid action changed state")

endmodule

/* dv/testbench.sv */
// self-checking bench for the mountain car step core: stream driver, monitor and physics predictor
module testbench;
    import mcps_pkg::*;

    typedef longint unsigned u64_t;

    localparam int COS_DEPTH = COS_TABLE_DEPTH_DEF;
    localparam int LONG_HOLD = 80;
    localparam int IDLE_LIMIT = 4000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // [1:0] action, [19:2] start_position, [33:20] start_velocity, [39:34] zero
    logic [39:0] s_tdata = '0;
    // [0] new_episode
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [17:0] position, [31:18] velocity, [32] done_res, [33] bad_action, [39:34] zero
    logic [39:0] m_tdata;

    mountain_car_physics_step_core #(
        .COS_TABLE_DEPTH(COS_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #5 aclk = ~aclk;

    int         cos_lut [COS_DEPTH];
    step_in_t   pending_beats [$];
    step_res_t  expected_res [$];
    car_state_t pred_car;
    car_state_t plan_car;
    step_in_t   cur_beat;
    step_res_t  drv_res;
    step_res_t  mon_res;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int ep_left = 0;
    int idle_cycles = 0;
    int n_fail = 0;
    int beats_in = 0;
    int results_seen = 0;
    int restarts = 0;
    int goal_hits = 0;
    int wall_hits = 0;
    int bad_pushes = 0;

    function automatic longint clamp_range(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // nearest, ties away from zero
    function automatic longint round_near(longint v, int s);
        u64_t m;
        m = (v < 0) ? u64_t'(-v) : u64_t'(v);
        m = (m + (u64_t'(1) << (s - 1))) >> s;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    // cosine in q30, angle folded into the first quadrant, taylor series to a^16
    function automatic longint cos_fix30(u64_t ang);
        u64_t   a;
        u64_t   a2;
        u64_t   term;
        longint acc;
        bit     flip;
        flip = 1'b0;
        a = ang;
        if (a > Q30_PI) begin
            a = a - Q30_PI;
            flip = 1'b1;
        end else if (a > Q30_HALF_PI) begin
            a = Q30_PI - a;
            flip = 1'b1;
        end
        a2 = (a * a) >> 30;
        term = Q30_ONE;
        acc = longint'(term);
        for (int k = 1; k <= 8; k++) begin
            term = ((term * a2) >> 30) / u64_t'((2 * k - 1) * (2 * k));
            if (k % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        return flip ? -acc : acc;
    endfunction

    task automatic build_cos_lut();
        longint p;
        u64_t   mag;
        for (int i = 0; i < COS_DEPTH; i++) begin
            p = POS_MIN + ((2 * longint'(i) + 1) * POS_SPAN) / (2 * longint'(COS_DEPTH));
            mag = (p < 0) ? u64_t'(-p) : u64_t'(p);
            cos_lut[i] = int'(round_near(cos_fix30((3 * mag) << (30 - FRACTION_BITS)),
                                         30 - FRACTION_BITS));
        end
    endtask

    function automatic step_res_t physics_step(car_state_t car, step_in_t b);
        step_res_t r;
        longint    x;
        longint    v;
        longint    idx;
        longint    g;
        longint    push;
        x = longint'($signed(car.pos));
        v = longint'($signed(car.vel));
        r.bad_action = 1'b0;
        if (b.new_episode) begin
            x = clamp_range(longint'($signed(b.start_pos)), POS_MIN, POS_MAX);
            v = clamp_range(longint'($signed(b.start_vel)), -VEL_MAX, VEL_MAX);
        end else if (b.action == ACT_BAD) begin
            r.bad_action = 1'b1;
        end else begin
            case (b.action)
                ACT_LEFT:  push = -1;
                ACT_RIGHT: push = 1;
                default:   push = 0;
            endcase
            x = clamp_range(x, POS_MIN, POS_MAX);
            idx = clamp_range(((x - POS_MIN) * COS_DEPTH) / POS_SPAN, 0, COS_DEPTH - 1);
            g = round_near(GRAVITY_GAIN * longint'(cos_lut[idx]), FRACTION_BITS);
            // position uses the velocity before its limit is applied
            v = v + push * PUSH_GAIN - g;
            x = x + v;
            if (x < POS_MIN) begin
                x = POS_MIN;
                v = 0;
            end else if (x > POS_MAX) begin
                x = POS_MAX;
                v = 0;
            end
            v = clamp_range(v, -VEL_MAX, VEL_MAX);
        end
        r.car.pos = POS_W'(x);
        r.car.vel = VEL_W'(v);
        r.done_res = (x == POS_MAX);
        return r;
    endfunction

    function automatic step_in_t mk_beat(action_t a, bit restart, longint sp, longint sv);
        step_in_t b;
        b.action = a;
        b.new_episode = restart;
        b.start_pos = POS_W'(sp);
        b.start_vel = VEL_W'(sv);
        return b;
    endfunction

    // the planning copy of the state lets the push policy follow the car
    task automatic queue_beat(step_in_t b);
        step_res_t r;
        r = physics_step(plan_car, b);
        plan_car = r.car;
        pending_beats.push_back(b);
    endtask

    task automatic queue_directed();
        queue_beat(mk_beat(ACT_NONE, 1'b0, 0, 0));
        queue_beat(mk_beat(ACT_BAD, 1'b0, -1, -1));
        queue_beat(mk_beat(ACT_BAD, 1'b1, -32768, 0));
        queue_beat(mk_beat(ACT_NONE, 1'b1, POS_MAX, 0));
        queue_beat(mk_beat(ACT_RIGHT, 1'b0, 0, 0));
        queue_beat(mk_beat(ACT_BAD, 1'b0, 0, 0));
        queue_beat(mk_beat(ACT_LEFT, 1'b1, -131072, -8192));
        queue_beat(mk_beat(ACT_LEFT, 1'b0, 0, 0));
        queue_beat(mk_beat(ACT_RIGHT, 1'b1, 131071, 8191));
        queue_beat(mk_beat(ACT_RIGHT, 1'b0, 0, 0));
        queue_beat(mk_beat(ACT_NONE, 1'b1, POS_MIN, VEL_MAX));
        queue_beat(mk_beat(ACT_RIGHT, 1'b0, 0, 0));
        queue_beat(mk_beat(ACT_LEFT, 1'b1, 0, -VEL_MAX));
        queue_beat(mk_beat(ACT_LEFT, 1'b0, 0, 0));
        queue_beat(mk_beat(ACT_RIGHT, 1'b1, POS_MIN - 1, -VEL_MAX - 1));
        queue_beat(mk_beat(ACT_NONE, 1'b0, 0, 0));
        queue_beat(mk_beat(ACT_LEFT, 1'b1, POS_MAX + 1, VEL_MAX + 1));
        queue_beat(mk_beat(ACT_NONE, 1'b0, 0, 0));
        queue_beat(mk_beat(ACT_NONE, 1'b1, POS_RESET, 0));
        queue_beat(mk_beat(ACT_LEFT, 1'b0, 0, 0));
        queue_beat(mk_beat(ACT_NONE, 1'b0, 0, 0));
        queue_beat(mk_beat(ACT_RIGHT, 1'b0, 0, 0));
    endtask

    // episodes: a restart, then mostly energy-pumping pushes with some noise
    task automatic queue_episodes(int n_beats);
        step_in_t b;
        for (int n = 0; n < n_beats; n++) begin
            b.start_pos = POS_W'($urandom);
            b.start_vel = VEL_W'($urandom);
            b.action = action_t'($urandom_range(0, 3));
            b.new_episode = 1'b0;
            if (ep_left == 0 || (plan_car.pos == POS_MAX_Q && $urandom_range(0, 9) < 7)) begin
                b.new_episode = 1'b1;
                ep_left = $urandom_range(40, 220);
                case ($urandom_range(0, 9))
                    0, 1: ;
                    2, 3: b.start_pos = POS_W'(POS_MAX - longint'($urandom_range(0, 6000)));
                    default: b.start_pos = POS_W'(POS_MIN +
                                                  longint'($urandom_range(0, int'(POS_SPAN - 1))));
                endcase
                if ($urandom_range(0, 9) > 2) begin
                    b.start_vel = VEL_W'(longint'($urandom_range(0, int'(2 * VEL_MAX))) - VEL_MAX);
                end
            end else begin
                ep_left--;
                if ($urandom_range(0, 99) < 8) begin
                    // keep the random push, invalid code included
                end else if ($urandom_range(0, 99) < 5) begin
                    b.action = ACT_NONE;
                end else begin
                    b.action = ($signed(plan_car.vel) >= 0) ? ACT_RIGHT : ACT_LEFT;
                end
            end
            queue_beat(b);
        end
    endtask

    task automatic drain_all();
        while (pending_beats.size() != 0 || s_tvalid || expected_res.size() != 0) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
            n_fail++;
        end
    endtask

    // driver: prediction is made at the accepting edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                drv_res = physics_step(pred_car, cur_beat);
                pred_car = drv_res.car;
                expected_res.push_back(drv_res);
                beats_in++;
                if (cur_beat.new_episode) restarts++;
                if (drv_res.done_res) goal_hits++;
                if (drv_res.bad_action) bad_pushes++;
                if (drv_res.car.pos == POS_MIN_Q && !cur_beat.new_episode) wall_hits++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    cur_beat = pending_beats.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {6'd0, cur_beat.start_vel, cur_beat.start_pos, cur_beat.action};
                    s_tuser <= cur_beat.new_episode;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor and result-side back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_res.size() == 0) begin
                    $display("%0t unexpected result beat: expected none actual %h", $time, m_tdata);
                    n_fail++;
                end else begin
                    mon_res = expected_res.pop_front();
                    check_field("position", longint'($signed(mon_res.car.pos)),
                                longint'($signed(m_tdata[17:0])));
                    check_field("velocity", longint'($signed(mon_res.car.vel)),
                                longint'($signed(m_tdata[31:18])));
                    check_field("done_res", longint'(mon_res.done_res), longint'(m_tdata[32]));
                    check_field("bad_action", longint'(mon_res.bad_action), longint'(m_tdata[33]));
                end
            end
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end else if (hold_seen != hold_req) begin
                hold_seen <= hold_req;
                hold_left <= LONG_HOLD;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t no beat moved for %0d cycles", $time, idle_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        pred_car.pos = POS_RESET_Q;
        pred_car.vel = '0;
        plan_car = pred_car;
        build_cos_lut();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        queue_directed();
        drain_all();
        // long receiver hold while the sender keeps offering
        hold_req = hold_req + 1;
        queue_episodes(285);
        drain_all();
        send_idle_pct = 82;
        queue_episodes(285);
        drain_all();
        send_idle_pct = 0;
        recv_stall_pct = 82;
        queue_episodes(285);
        drain_all();
        send_idle_pct = 31;
        recv_stall_pct = 31;
        queue_episodes(285);
        drain_all();
        repeat (8) @(posedge aclk);
        if (expected_res.size() != 0) begin
            $display("%0t %0d result beats never arrived", $time, expected_res.size());
            n_fail++;
        end
        $display("run covered %0d input beats and %0d result beats over five stall patterns",
                 beats_in, results_seen);
        $display("episodes restarted %0d, goal reached %0d, left wall %0d, invalid pushes %0d",
                 restarts, goal_hits, wall_hits, bad_pushes);
        if (n_fail == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/mcps_pkg.sv
src/mcps_grav_rom.sv
src/mcps_step.sv
src/mountain_car_physics_step_core.sv
dv/testbench.sv
